### rtl/atrb_pkg.sv
// Shared types and constants for the aged trace ring buffer.
// No dependencies; every other file in the project imports it.
package atrb_pkg;

  localparam int TICK_W     = 64;
  localparam int UTC_W      = 64;
  localparam int STAMP_W    = 64;
  localparam int DAYNUM_W   = 38;
  localparam int DAY_W      = 27;
  localparam int STEP_W     = 3;
  localparam int RET_W      = 63;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 64;

  // Day split: 86400000 = 84375 << 10, quotient by reciprocal of the odd part
  localparam int MUL_W     = 32;
  localparam int DAY_SHIFT = 10;
  localparam int QIN_W     = 54;
  localparam int ODD_W     = 17;
  localparam int RECIP_W   = 55;
  localparam int ACC_W     = 109;
  localparam int QPOS      = 71;

  localparam logic [DAY_W-1:0]     DAY_MS        = 27'd86400000;
  localparam logic [RET_W-1:0]     RETENTION_RST = 63'd86400000;
  localparam logic [ODD_W-1:0]     DAY_ODD       = 17'd84375;
  // ceil(2^71 / 84375)
  localparam logic [RECIP_W-1:0]   DAY_RECIP     = 55'd27984393972560861;

  localparam logic [CFG_IDX_W-1:0] REG_RETENTION = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START     = 8'd1;

  localparam logic OP_APPEND  = 1'b0;
  localparam logic OP_READOUT = 1'b1;

  // Multiplier steps of the day split
  localparam logic [STEP_W-1:0] MUL_LL  = 3'd0;
  localparam logic [STEP_W-1:0] MUL_LH  = 3'd1;
  localparam logic [STEP_W-1:0] MUL_HL  = 3'd2;
  localparam logic [STEP_W-1:0] MUL_HH  = 3'd3;
  localparam logic [STEP_W-1:0] MUL_REM = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EV_RD,
    ST_EV_CHK,
    ST_APPEND,
    ST_RO_START,
    ST_RO_RD,
    ST_RO_PREP,
    ST_RO_DIV,
    ST_RO_EMIT
  } state_t;

endpackage

### rtl/atrb_ifs.sv
// Valid/ready channel interfaces: input words, result words and register writes.
// Depends on atrb_pkg for field widths.
interface atrb_in_if #(parameter int PAYLOAD_BITS = 64);
  import atrb_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic [TICK_W-1:0]       now_tick;
  logic signed [UTC_W-1:0] utc_ms;
  logic                    clock_trusted;
  logic [PAYLOAD_BITS-1:0] payload;
  modport source (output valid, opcode, now_tick, utc_ms, clock_trusted, payload,
                  input ready);
  modport sink   (input valid, opcode, now_tick, utc_ms, clock_trusted, payload,
                  output ready);
endinterface

interface atrb_out_if #(parameter int PAYLOAD_BITS = 64);
  import atrb_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       entry_valid;
  logic                       new_day;
  logic                       stamp_trusted;
  logic signed [DAYNUM_W-1:0] day_number;
  logic [STAMP_W-1:0]         stamp_ms;
  logic [PAYLOAD_BITS-1:0]    entry_payload;
  logic                       is_last;
  modport source (output valid, entry_valid, new_day, stamp_trusted, day_number,
                  stamp_ms, entry_payload, is_last, input ready);
  modport sink   (input valid, entry_valid, new_day, stamp_trusted, day_number,
                  stamp_ms, entry_payload, is_last, output ready);
endinterface

interface atrb_cfg_if;
  import atrb_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/aged_trace_ring_buffer.sv
// Aged trace ring buffer: entry memory, eviction walk and read-out with day split.
// Depends on atrb_pkg and the channel interfaces in atrb_ifs.sv.
//
// A ring of DEPTH trace entries (tick, UTC stamp, trust flag, payload word) held in
// one single-port-write, registered-read memory. Each input word first walks the
// head of the ring and drops entries whose age (now_tick minus entry tick, clamped
// at zero) has reached retention_ms; each check needs one memory read. An append
// word then writes one entry (overwriting the oldest when full). A read-out word
// gives one result word per entry, oldest first: a trusted entry with a nonzero
// stamp goes through the shared 32 by 32 multiplier that splits the UTC stamp
// into day number and time of day, an untrusted one skips it: four partial products
// of a reciprocal multiplication give the quotient, a fifth gives the remainder.
// An empty ring gives a single word with entry_valid low and is_last
// high. The input side is not ready while a word is being worked on. Results sit
// in an output register, so the next input word is taken while the final result of
// a read-out still waits. The memory has no reset and no clearing pass; only
// entries written since reset are ever read. Configuration writes are taken at any
// time and should only be issued while the block is idle.
module aged_trace_ring_buffer #(
  parameter int DEPTH        = 64,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  atrb_in_if.sink    in_ch,
  atrb_out_if.source out_ch,
  atrb_cfg_if.sink   cfg_ch
);
  import atrb_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int ENT_W = TICK_W + UTC_W + 1 + PAYLOAD_BITS;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  // Configuration registers
  logic [RET_W-1:0]  retention_r;
  logic [TICK_W-1:0] start_tick_r;

  // Sequencer and ring pointers
  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  head_r;
  logic [CNT_W-1:0]  count_r;
  logic [IDX_W-1:0]  ptr_r;
  logic [CNT_W-1:0]  left_r;

  // Latched input word
  logic                    op_r;
  logic [TICK_W-1:0]       now_r;
  logic [UTC_W-1:0]        utc_in_r;
  logic                    trusted_in_r;
  logic [PAYLOAD_BITS-1:0] payload_in_r;

  // Entry memory
  logic [ENT_W-1:0] mem [DEPTH];
  logic [ENT_W-1:0] rd_data_r;

  // Day split and day tracking
  logic [QIN_W-1:0]     quo_in_r;
  logic [DAY_SHIFT-1:0] low_r;
  logic [ACC_W-1:0]     acc_r;
  logic [DAY_W-1:0]     rem_r;
  logic [DAYNUM_W-1:0]  num_r;
  logic [STEP_W-1:0]    step_r;
  logic                 neg_r;
  logic                 tr_r;
  logic                 have_day_r;
  logic [DAYNUM_W-1:0]  last_day_r;

  // Output register
  logic                    out_valid_r;
  logic                    out_entry_valid_r;
  logic                    out_new_day_r;
  logic                    out_stamp_trusted_r;
  logic [DAYNUM_W-1:0]     out_day_r;
  logic [STAMP_W-1:0]      out_stamp_r;
  logic [PAYLOAD_BITS-1:0] out_payload_r;
  logic                    out_last_r;

  // Sequencer outputs
  logic             in_rdy;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic             ev_pop;
  logic             ro_init;
  logic             prep;
  logic             div_step;
  logic             emit;
  logic             emit_empty;

  // Combinational datapath
  logic                    in_acc;
  logic                    out_free;
  logic [TICK_W-1:0]       ent_tick;
  logic [UTC_W-1:0]        ent_utc;
  logic                    ent_trusted;
  logic [PAYLOAD_BITS-1:0] ent_word;
  logic [TICK_W-1:0]       age;
  logic                    evict;
  logic [CNT_W:0]          tail_sum;
  logic [IDX_W-1:0]        tail_idx;
  logic                    ring_full;
  logic [UTC_W-1:0]        mag;
  logic [MUL_W-1:0]        mul_a;
  logic [MUL_W-1:0]        mul_b;
  logic [2*MUL_W-1:0]      mul_p;
  logic [ACC_W-1:0]        addend;
  logic [MUL_W-1:0]        rem_low;
  logic [DAYNUM_W-1:0]     day;
  logic [DAY_W-1:0]        tod;
  logic [TICK_W-1:0]       rel_stamp;
  logic                    last_step;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
    idx_inc = (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

  assign in_acc   = in_ch.valid && in_rdy;
  assign out_free = !out_valid_r || out_ch.ready;

  assign ent_tick    = rd_data_r[ENT_W-1 -: TICK_W];
  assign ent_utc     = rd_data_r[ENT_W-TICK_W-1 -: UTC_W];
  assign ent_trusted = rd_data_r[PAYLOAD_BITS];
  assign ent_word    = rd_data_r[PAYLOAD_BITS-1:0];

  // Age of the head entry, clamped at zero
  assign age   = (now_r >= ent_tick) ? (now_r - ent_tick) : '0;
  assign evict = (age >= {1'b0, retention_r});

  // Slot after the newest entry
  assign tail_sum  = {{(CNT_W + 1 - IDX_W){1'b0}}, head_r} + {1'b0, count_r};
  assign tail_idx  = (tail_sum >= (CNT_W + 1)'(DEPTH)) ?
                     IDX_W'(tail_sum - (CNT_W + 1)'(DEPTH)) : IDX_W'(tail_sum);
  assign ring_full = (count_r == FULL_CNT);

  // Magnitude of the UTC stamp for the day split
  assign mag = ent_utc[UTC_W-1] ? (~ent_utc + 1'b1) : ent_utc;

  // Shared multiplier operands: four partial products of the shifted magnitude
  // times the reciprocal, then the low quotient word times the odd divisor
  always_comb begin
    mul_a = quo_in_r[MUL_W-1:0];
    mul_b = DAY_RECIP[MUL_W-1:0];
    unique case (step_r)
      MUL_LH:  mul_b = MUL_W'(DAY_RECIP[RECIP_W-1:MUL_W]);
      MUL_HL:  mul_a = MUL_W'(quo_in_r[QIN_W-1:MUL_W]);
      MUL_HH: begin
        mul_a = MUL_W'(quo_in_r[QIN_W-1:MUL_W]);
        mul_b = MUL_W'(DAY_RECIP[RECIP_W-1:MUL_W]);
      end
      MUL_REM: begin
        mul_a = acc_r[QPOS +: MUL_W];
        mul_b = MUL_W'(DAY_ODD);
      end
      default: mul_a = quo_in_r[MUL_W-1:0];
    endcase
  end

  assign mul_p = (2 * MUL_W)'(mul_a) * (2 * MUL_W)'(mul_b);

  // Line the partial product up with its weight in the accumulator
  always_comb begin
    unique case (step_r)
      MUL_LH, MUL_HL: addend = ACC_W'(mul_p) << MUL_W;
      MUL_HH:         addend = ACC_W'(mul_p) << (2 * MUL_W);
      default:        addend = ACC_W'(mul_p);
    endcase
  end

  // Remainder of the odd division fits in its low bits, so one word is enough
  assign rem_low   = quo_in_r[MUL_W-1:0] - mul_p[MUL_W-1:0];
  assign last_step = (step_r == MUL_REM);

  // Floor division result: round towards minus infinity for negative stamps
  always_comb begin
    day = num_r;
    tod = rem_r;
    if (neg_r) begin
      if (rem_r != '0) begin
        day = ~num_r;
        tod = DAY_MS - rem_r;
      end else begin
        day = ~num_r + 1'b1;
        tod = '0;
      end
    end
  end

  assign rel_stamp = (ent_tick >= start_tick_r) ? (ent_tick - start_tick_r) : '0;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_acc) state_nxt = ST_EV_RD;
      ST_EV_RD: begin
        if (count_r != '0) state_nxt = ST_EV_CHK;
        else if (op_r == OP_APPEND) state_nxt = ST_APPEND;
        else state_nxt = ST_RO_START;
      end
      ST_EV_CHK: begin
        if (evict) state_nxt = ST_EV_RD;
        else if (op_r == OP_APPEND) state_nxt = ST_APPEND;
        else state_nxt = ST_RO_START;
      end
      ST_APPEND:   state_nxt = ST_IDLE;
      ST_RO_START: begin
        if (count_r != '0) state_nxt = ST_RO_RD;
        else if (out_free) state_nxt = ST_IDLE;
      end
      ST_RO_RD:    state_nxt = ST_RO_PREP;
      ST_RO_PREP:  state_nxt = (ent_trusted && ent_utc != '0) ? ST_RO_DIV : ST_RO_EMIT;
      ST_RO_DIV:   if (last_step) state_nxt = ST_RO_EMIT;
      ST_RO_EMIT: begin
        if (out_free) state_nxt = (left_r == CNT_W'(1)) ? ST_IDLE : ST_RO_RD;
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_rdy     = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = head_r;
    mem_we     = 1'b0;
    ev_pop     = 1'b0;
    ro_init    = 1'b0;
    prep       = 1'b0;
    div_step   = 1'b0;
    emit       = 1'b0;
    emit_empty = 1'b0;
    unique case (state_r)
      ST_IDLE:     in_rdy = 1'b1;
      ST_EV_RD:    rd_en = (count_r != '0);
      ST_EV_CHK:   ev_pop = evict;
      ST_APPEND:   mem_we = 1'b1;
      ST_RO_START: begin
        ro_init    = (count_r != '0);
        emit_empty = (count_r == '0) && out_free;
      end
      ST_RO_RD: begin
        rd_en   = 1'b1;
        rd_addr = ptr_r;
      end
      ST_RO_PREP:  prep = 1'b1;
      ST_RO_DIV:   div_step = 1'b1;
      ST_RO_EMIT:  emit = out_free;
      default:     in_rdy = 1'b0;
    endcase
  end

  // Entry memory: one write port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ring_full ? head_r : tail_idx] <= {now_r, utc_in_r, trusted_in_r, payload_in_r};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      head_r       <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      have_day_r   <= 1'b0;
      retention_r  <= RETENTION_RST;
      start_tick_r <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_ch.valid) begin
        if (cfg_ch.index == REG_RETENTION) retention_r <= cfg_ch.data[RET_W-1:0];
        else if (cfg_ch.index == REG_START) start_tick_r <= cfg_ch.data;
      end

      // Drop the oldest entry, or advance the head when an append overwrites it
      if (ev_pop) begin
        head_r  <= idx_inc(head_r);
        count_r <= count_r - 1'b1;
      end else if (mem_we) begin
        if (ring_full) head_r <= idx_inc(head_r);
        else count_r <= count_r + 1'b1;
      end

      if (ro_init) have_day_r <= 1'b0;
      else if (emit && tr_r) have_day_r <= 1'b1;

      if (emit || emit_empty) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r         <= in_ch.opcode;
      now_r        <= in_ch.now_tick;
      utc_in_r     <= in_ch.utc_ms;
      trusted_in_r <= in_ch.clock_trusted;
      payload_in_r <= PAYLOAD_BITS'(in_ch.payload);
    end

    if (ro_init) begin
      ptr_r  <= head_r;
      left_r <= count_r;
    end else if (emit) begin
      ptr_r  <= idx_inc(ptr_r);
      left_r <= left_r - 1'b1;
    end

    // Split the magnitude into the part above the ten low bits and those bits;
    // accumulate the reciprocal product, then take the remainder on the last step
    if (prep) begin
      tr_r     <= ent_trusted && (ent_utc != '0);
      neg_r    <= ent_utc[UTC_W-1];
      quo_in_r <= mag[UTC_W-1:DAY_SHIFT];
      low_r    <= mag[DAY_SHIFT-1:0];
      acc_r    <= '0;
      step_r   <= MUL_LL;
    end else if (div_step) begin
      if (last_step) begin
        num_r <= acc_r[QPOS +: DAYNUM_W];
        rem_r <= {rem_low[ODD_W-1:0], low_r};
      end else begin
        acc_r <= acc_r + addend;
      end
      step_r <= step_r + 1'b1;
    end

    if (emit && tr_r) last_day_r <= day;

    if (emit) begin
      out_entry_valid_r   <= 1'b1;
      out_stamp_trusted_r <= tr_r;
      out_new_day_r       <= tr_r && (!have_day_r || day != last_day_r);
      out_day_r           <= tr_r ? day : '0;
      out_stamp_r         <= tr_r ? STAMP_W'(tod) : rel_stamp;
      out_payload_r       <= ent_word;
      out_last_r          <= (left_r == CNT_W'(1));
    end else if (emit_empty) begin
      out_entry_valid_r   <= 1'b0;
      out_stamp_trusted_r <= 1'b0;
      out_new_day_r       <= 1'b0;
      out_day_r           <= '0;
      out_stamp_r         <= '0;
      out_payload_r       <= '0;
      out_last_r          <= 1'b1;
    end
  end

  assign in_ch.ready  = in_rdy;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.entry_valid   = out_entry_valid_r;
  assign out_ch.new_day       = out_new_day_r;
  assign out_ch.stamp_trusted = out_stamp_trusted_r;
  assign out_ch.day_number    = out_day_r;
  assign out_ch.stamp_ms      = out_stamp_r;
  assign out_ch.entry_payload = out_payload_r;
  assign out_ch.is_last       = out_last_r;

endmodule

### test/atrb_tb_pkg.sv
// Word types and the result scoreboard for the aged trace ring buffer bench.
// Depends on atrb_pkg for opcodes and register indexes.
package atrb_tb_pkg;
  import atrb_pkg::*;

  localparam int     RING_SLOTS = 64;
  localparam longint DAY_LEN    = 64'sd86400000;

  typedef struct {
    logic        op;
    logic [63:0] now_tick;
    logic [63:0] utc_ms;
    logic        trusted;
    logic [63:0] payload;
  } trace_word_t;

  typedef struct {
    logic        entry_valid;
    logic        new_day;
    logic        stamp_trusted;
    logic [37:0] day_number;
    logic [63:0] stamp_ms;
    logic [63:0] entry_payload;
    logic        is_last;
  } trace_result_t;

  class trace_ring_scoreboard;
    logic [63:0]   ring_tick [RING_SLOTS];
    logic [63:0]   ring_utc [RING_SLOTS];
    logic          ring_trusted [RING_SLOTS];
    logic [63:0]   ring_word [RING_SLOTS];
    int unsigned   head;
    int unsigned   count;
    logic [62:0]   retention;
    logic [63:0]   start_tick;
    trace_result_t due_results[$];
    int unsigned   errors;

    function new();
      head       = 0;
      count      = 0;
      retention  = RETENTION_RST;
      start_tick = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [63:0] data);
      if (idx == REG_RETENTION) retention = data[62:0];
      else if (idx == REG_START) start_tick = data;
    endfunction

    // Drop aged entries from the head, then append or queue the read-out results.
    function void note_word(trace_word_t w);
      logic [63:0]   age;
      int unsigned   slot;
      bit            have_day;
      bit            tr;
      longint        utc;
      longint        day;
      longint        tod;
      longint        last_day;
      trace_result_t r;
      while (count > 0) begin
        age = (w.now_tick >= ring_tick[head]) ? w.now_tick - ring_tick[head] : 64'd0;
        if (age < {1'b0, retention}) break;
        head = (head + 1) % RING_SLOTS;
        count--;
      end
      if (w.op == OP_APPEND) begin
        if (count < RING_SLOTS) begin
          slot = (head + count) % RING_SLOTS;
          count++;
        end else begin
          slot = head;
          head = (head + 1) % RING_SLOTS;
        end
        ring_tick[slot]    = w.now_tick;
        ring_utc[slot]     = w.utc_ms;
        ring_trusted[slot] = w.trusted;
        ring_word[slot]    = w.payload;
        return;
      end
      r = '{default: '0};
      if (count == 0) begin
        r.is_last = 1'b1;
        due_results.push_back(r);
        return;
      end
      have_day = 1'b0;
      last_day = 0;
      for (int i = 0; i < count; i++) begin
        slot            = (head + i) % RING_SLOTS;
        tr              = ring_trusted[slot] && (ring_utc[slot] != 64'd0);
        r               = '{default: '0};
        r.entry_valid   = 1'b1;
        r.stamp_trusted = tr;
        if (tr) begin
          // floor division: pull a negative remainder back into the day
          utc = ring_utc[slot];
          day = utc / DAY_LEN;
          tod = utc % DAY_LEN;
          if (tod < 0) begin
            day = day - 1;
            tod = tod + DAY_LEN;
          end
          if (!have_day || day != last_day) begin
            r.new_day = 1'b1;
            have_day  = 1'b1;
            last_day  = day;
          end
          r.day_number = day[37:0];
          r.stamp_ms   = tod;
        end else begin
          r.stamp_ms = (ring_tick[slot] >= start_tick) ? ring_tick[slot] - start_tick : 64'd0;
        end
        r.entry_payload = ring_word[slot];
        r.is_last       = (i == count - 1);
        due_results.push_back(r);
      end
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_word(trace_result_t got);
      trace_result_t want;
      if (due_results.size() == 0) begin
        $error("result word arrived with nothing expected");
        errors++;
        return;
      end
      want = due_results.pop_front();
      compare("entry_valid", want.entry_valid, got.entry_valid);
      compare("new_day", want.new_day, got.new_day);
      compare("stamp_trusted", want.stamp_trusted, got.stamp_trusted);
      compare("day_number", want.day_number, got.day_number);
      compare("stamp_ms", want.stamp_ms, got.stamp_ms);
      compare("entry_payload", want.entry_payload, got.entry_payload);
      compare("is_last", want.is_last, got.is_last);
    endfunction
  endclass

endpackage

### test/tb_aged_trace_ring_buffer.sv
// Self-checking bench for aged_trace_ring_buffer: directed and random words, random stalls.
// Depends on atrb_pkg, atrb_ifs.sv, the block itself and atrb_tb_pkg (scoreboard).
module tb_aged_trace_ring_buffer;
  timeunit 1ns;
  timeprecision 1ps;
  import atrb_pkg::*;
  import atrb_tb_pkg::*;

  localparam int          PB           = 64;
  localparam longint      CYCLE_LIMIT  = 20000000;
  // the eviction walk of a full ring reads every slot; allow well over its worst case
  localparam int          DRAIN_CYCLES = 300;
  localparam int          LONG_HOLD    = 400;
  // indexes that decode to no register; writes to them must change nothing
  localparam logic [7:0]  REG_SPARE_A  = 8'h02;
  localparam logic [7:0]  REG_SPARE_B  = 8'hFF;
  localparam logic [62:0] RET_MAX      = {63{1'b1}};
  localparam logic [63:0] ALL_ONES     = {64{1'b1}};

  logic clk = 1'b0;
  logic rst_n;

  atrb_in_if  #(.PAYLOAD_BITS(PB)) in_ch ();
  atrb_out_if #(.PAYLOAD_BITS(PB)) out_ch ();
  atrb_cfg_if                      cfg_ch ();

  aged_trace_ring_buffer #(
    .DEPTH        (RING_SLOTS),
    .PAYLOAD_BITS (PB)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  trace_ring_scoreboard sb = new();

  longint      cycle_count = 0;
  int unsigned quiet_items = 0;
  logic [63:0] tick_now;
  longint      utc_now;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Idle length from three random ranges: mostly the shortest, now and then the longest.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  // Offer one word, hold it until taken, then note it and maybe go idle.
  task automatic send_word(input trace_word_t w);
    int unsigned gap;
    in_ch.valid         <= 1'b1;
    in_ch.opcode        <= w.op;
    in_ch.now_tick      <= w.now_tick;
    in_ch.utc_ms        <= w.utc_ms;
    in_ch.clock_trusted <= w.trusted;
    in_ch.payload       <= w.payload;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_word(w);
    // runs of back-to-back words alternate with random gaps
    if (quiet_items > 0) begin
      quiet_items--;
    end else if ($urandom_range(0, 19) == 0) begin
      quiet_items = $urandom_range(10, 40);
    end else if ($urandom_range(0, 2) == 0) begin
      gap = idle_len();
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic put(input logic op, input logic [63:0] now, input logic [63:0] utc,
                     input logic tr, input logic [63:0] pl);
    trace_word_t w;
    w.op       = op;
    w.now_tick = now;
    w.utc_ms   = utc;
    w.trusted  = tr;
    w.payload  = pl;
    send_word(w);
  endtask

  // Wait until every expected result is in and the block takes input again,
  // then let any trailing eviction walk finish before touching registers.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.due_results.size() != 0 || !in_ch.ready) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back, optionally followed by writes to dead indexes.
  task automatic set_config(input logic [62:0] ret, input logic [63:0] start,
                            input bit poke_spare);
    logic [7:0]  idx [4];
    logic [63:0] val [4];
    int          n;
    idx[0] = REG_RETENTION;
    val[0] = {1'b0, ret};
    idx[1] = REG_START;
    val[1] = start;
    idx[2] = REG_SPARE_A;
    val[2] = 64'd1;
    idx[3] = REG_SPARE_B;
    val[3] = ALL_ONES;
    n = poke_spare ? 4 : 2;
    cfg_ch.valid <= 1'b1;
    for (int k = 0; k < n; k++) begin
      cfg_ch.index <= idx[k];
      cfg_ch.data  <= val[k];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      sb.write_reg(idx[k], val[k]);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Random words: ticks advance in small steps so entries age out gradually, UTC
  // stamps drift across day boundaries; a few words jump the tick anywhere
  // (backwards or far ahead) and a few carry zero or fully random stamps.
  task automatic run_phase(input int append_pct, input logic [63:0] step_max,
                           input int noise_pct, input int n_items);
    trace_word_t w;
    int unsigned r;
    utc_now = (longint'($urandom_range(0, 2000)) - 1000) * DAY_LEN
              + longint'($urandom_range(0, 86399999));
    for (int i = 0; i < n_items; i++) begin
      w.op = ($urandom_range(0, 99) < append_pct) ? OP_APPEND : OP_READOUT;
      if ($urandom_range(0, 99) < noise_pct) tick_now = {$urandom, $urandom};
      else tick_now = tick_now + ({$urandom, $urandom} % (step_max + 64'd1));
      w.now_tick = tick_now;
      r = $urandom_range(0, 99);
      if (r < 8) begin
        w.utc_ms = '0;
      end else if (r < 18) begin
        w.utc_ms = {$urandom, $urandom};
      end else begin
        utc_now  = utc_now + longint'($urandom_range(0, 40000000));
        w.utc_ms = utc_now;
      end
      w.trusted = ($urandom_range(0, 4) != 0);
      w.payload = {$urandom, $urandom};
      send_word(w);
    end
  endtask

  // Result side: check each taken word, stall at random, and hold off once for a
  // long stretch in mid read-out so the output backs up and input stalls.
  initial begin : result_sink
    int unsigned   stall;
    int unsigned   hold;
    int unsigned   steady;
    int unsigned   seen;
    bit            held_once;
    trace_result_t got;
    stall     = 0;
    hold      = 0;
    steady    = 0;
    seen      = 0;
    held_once = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.entry_valid   = out_ch.entry_valid;
        got.new_day       = out_ch.new_day;
        got.stamp_trusted = out_ch.stamp_trusted;
        got.day_number    = out_ch.day_number;
        got.stamp_ms      = out_ch.stamp_ms;
        got.entry_payload = out_ch.entry_payload;
        got.is_last       = out_ch.is_last;
        sb.check_word(got);
        seen++;
        if (!held_once && seen > 120 && !out_ch.is_last) begin
          held_once = 1'b1;
          hold      = LONG_HOLD;
        end
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (steady > 0) steady--;
        else if ($urandom_range(0, 99) < 3) steady = $urandom_range(50, 300);
        else if ($urandom_range(0, 3) == 0) stall = idle_len();
      end
    end
  end

  // Give up on a hung run.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.opcode        <= OP_APPEND;
    in_ch.now_tick      <= '0;
    in_ch.utc_ms        <= '0;
    in_ch.clock_trusted <= 1'b0;
    in_ch.payload       <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= REG_RETENTION;
    cfg_ch.data         <= '0;
    tick_now = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words under the reset register values.
    put(OP_READOUT, 64'd0, 64'd0, 1'b0, 64'd0);               // empty ring
    put(OP_APPEND, 64'd0, 64'd0, 1'b1, ALL_ONES);             // zero stamp: untrusted
    put(OP_APPEND, 64'd1, ALL_ONES, 1'b1, 64'd0);             // one ms before epoch
    put(OP_APPEND, 64'd2, 64'h8000_0000_0000_0000, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA);
    put(OP_APPEND, 64'd3, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 64'h5555_5555_5555_5555);
    put(OP_APPEND, 64'd4, 64'd432000000, 1'b1, 64'h0123_4567_89AB_CDEF); // day start
    put(OP_APPEND, 64'd5, 64'd432000001, 1'b1, 64'd5);        // same day
    put(OP_APPEND, 64'd6, 64'd12345, 1'b0, 64'd6);            // untrusted between
    put(OP_APPEND, 64'd7, 64'd432000002, 1'b1, 64'd7);        // still same day
    put(OP_APPEND, 64'd8, 64'(-DAY_LEN), 1'b1, 64'd8);        // exact negative day
    put(OP_READOUT, 64'd10, 64'd0, 1'b0, 64'd0);
    put(OP_READOUT, 64'd86400000, 64'd0, 1'b0, 64'd0);        // age equals retention
    put(OP_READOUT, 64'd0, 64'd0, 1'b1, 64'd0);               // tick runs backwards
    put(OP_APPEND, ALL_ONES, 64'd0, 1'b0, 64'hFEED);          // huge age drops all
    put(OP_READOUT, ALL_ONES, 64'd0, 1'b0, 64'd0);

    // Retention of zero drops everything on every word; start at its top end.
    settle();
    set_config(63'd0, ALL_ONES, 1'b0);
    put(OP_APPEND, 64'd5, 64'd7, 1'b1, 64'd9);
    put(OP_READOUT, 64'd5, 64'd0, 1'b0, 64'd0);

    // Smallest nonzero retention: an entry lives only while the tick stands still.
    settle();
    set_config(63'd1, ALL_ONES, 1'b0);
    put(OP_APPEND, 64'd100, 64'd99, 1'b0, 64'd10);
    put(OP_READOUT, 64'd100, 64'd0, 1'b0, 64'd0);             // relative stamp clamps
    put(OP_READOUT, 64'd101, 64'd0, 1'b0, 64'd0);

    // Random phases across register settings, extremes among them.
    settle();
    set_config(RET_MAX, 64'd0, 1'b0);
    tick_now = 64'd1000;
    run_phase(90, 64'd1000, 0, 90);                           // fill and overwrite

    settle();
    set_config(63'd5000, {$urandom, $urandom}, 1'b0);
    run_phase(75, 64'd600, 4, 70);

    settle();
    set_config(63'd1, ALL_ONES, 1'b0);
    run_phase(60, 64'd3, 4, 50);

    settle();
    set_config(63'({$urandom, $urandom} >> $urandom_range(1, 40)), {$urandom, $urandom}, 1'b0);
    run_phase(75, 64'd1 << 40, 6, 60);

    settle();
    set_config(RETENTION_RST, 64'd0, 1'b1);
    run_phase(80, 64'd5000000, 4, 70);

    settle();
    set_config(63'd200, tick_now - 64'd1000 + 64'($urandom_range(0, 2000)), 1'b0);
    run_phase(70, 64'd40, 5, 70);

    // Drain: wait for all results, then a quiet spell to catch strays.
    in_ch.valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.due_results.size() != 0)
      $error("%0d expected results never arrived", sb.due_results.size());
    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
